[hdl/xmr_pkg.sv]
// xmr_pkg: shared types and constants of the xmodem receiver
// no dependencies; imported by every module of the block

package xmr_pkg;

    // default block sizes
    localparam int LARGE_BLOCK_BYTES_DEF = 1024;
    localparam int SMALL_BLOCK_BYTES_DEF = 128;

    // timer ticks in one second after reset
    localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd19;

    // timer width and saturation value
    localparam int          TICK_W   = 19;
    localparam logic [18:0] TICK_MAX = 19'h7FFFF;

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // cancel burst: ten CAN, ten BS, then the end marker
    localparam int          BURST_LEN = 10;
    localparam int          STEP_W    = 5;

    // line control characters
    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] NAK_BYTE = 8'h15;
    localparam logic [7:0] CAN_BYTE = 8'h18;
    localparam logic [7:0] BS_BYTE  = 8'h08;

    // input commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;

    // register addresses (word index)
    localparam logic REG_TICKS_PER_SECOND = 1'b0;

    // result kinds
    typedef enum logic [2:0] {
        KIND_TX      = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_COMMIT  = 3'd2,
        KIND_DISCARD = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    // results caused by one input item: up to two leading items,
    // optionally followed by the cancel burst and the end marker
    typedef struct packed {
        logic       valid;
        logic       burst;
        logic [1:0] cnt;
        kind_t      kind0;
        logic [7:0] byte0;
        kind_t      kind1;
        logic [7:0] byte1;
    } desc_t;

    // append one leading item to a descriptor
    function automatic desc_t add_lead(desc_t d, kind_t k, logic [7:0] by);
        desc_t r;
        r = d;
        if (d.cnt == 2'd0)
        begin
            r.kind0 = k;
            r.byte0 = by;
        end
        else
        begin
            r.kind1 = k;
            r.byte1 = by;
        end
        r.cnt   = d.cnt + 2'd1;
        r.valid = 1'b1;
        return r;
    endfunction

endpackage

[hdl/xmodem_receiver.sv]
// xmodem_receiver: top level of the xmodem checksum receiver
// depends on xmr_pkg, xmr_front, xmr_queue and xmr_back
//
//   channel   direction  handshake        payload
//   input     in         push / full      cmd, line_byte
//   result    out        pop / empty      result_kind, result_byte, is_last
//   config    in         apb psel/penable paddr, pwdata, prdata
//
// unless full the front takes one input item per cycle and decides it in that cycle
// the back sends one result per cycle while popped, from a registered output stage
// an item expands to at most 22 results; a four-entry descriptor queue sits between
// full rises when the descriptor queue is full, whatever the next item would cause
// reset initialises all control state; the block is ready in the cycle after reset

module xmodem_receiver #(
    parameter int LARGE_BLOCK_BYTES = xmr_pkg::LARGE_BLOCK_BYTES_DEF,
    parameter int SMALL_BLOCK_BYTES = xmr_pkg::SMALL_BLOCK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [7:0]  line_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [7:0]  result_byte,
    output logic        is_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import xmr_pkg::*;

    logic [15:0] tps_reg, tps_next;
    logic        accept, q_push, q_pop, q_full, q_empty;
    desc_t       front_desc, q_head;

    // configuration register
    assign pready   = 1'b1;
    assign tps_next = (psel && penable && pwrite && paddr[2] == REG_TICKS_PER_SECOND)
                      ? pwdata[15:0] : tps_reg;
    assign prdata   = (paddr[2] == REG_TICKS_PER_SECOND) ? {16'h0000, tps_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_reg <= TICKS_PER_SECOND_RST;
        else
            tps_reg <= tps_next;
    end

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept && front_desc.valid;

    // front: protocol decisions
    xmr_front #(
        .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .cmd              (cmd),
        .line_byte        (line_byte),
        .ticks_per_second (tps_reg),
        .desc             (front_desc)
    );

    // descriptor queue
    xmr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_desc),
        .pop   (q_pop),
        .dout  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    // back: result sequencing
    xmr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .result_kind (result_kind),
        .result_byte (result_byte),
        .is_last     (is_last)
    );

    // checks
    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("descriptor pushed into a full queue");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result_kind <= 3'(KIND_END)))
        else $error("result kind out of range");

    a_verdict_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != 3'(KIND_TX) && result_kind != 3'(KIND_DATA))
        |-> (result_byte == 8'h00))
        else $error("verdict transaction carries a nonzero byte");

endmodule

[hdl/xmr_front.sv]
// xmr_front: protocol state machine, one input transaction per cycle
// depends on xmr_pkg; emits at most one result descriptor per transaction

module xmr_front #(
    parameter int LARGE_BLOCK_BYTES = xmr_pkg::LARGE_BLOCK_BYTES_DEF,
    parameter int SMALL_BLOCK_BYTES = xmr_pkg::SMALL_BLOCK_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [1:0]     cmd,
    input  logic [7:0]     line_byte,
    input  logic [15:0]    ticks_per_second,
    output xmr_pkg::desc_t desc
);
    import xmr_pkg::*;

    typedef enum logic [6:0] {
        PH_WAIT_HEADER = 7'b0000001,
        PH_PURGE       = 7'b0000010,
        PH_BLOCK_NUM   = 7'b0000100,
        PH_BLOCK_COMP  = 7'b0001000,
        PH_DATA        = 7'b0010000,
        PH_CHECKSUM    = 7'b0100000,
        PH_ENDED       = 7'b1000000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [7:0]          expected_reg, expected_next;
    logic [7:0]          received_reg, received_next;
    logic [7:0]          sum_reg, sum_next;
    logic [10:0]         pos_reg, pos_next;
    logic                large_reg, large_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;
    logic [TICK_W-1:0]   limit_reg, limit_next;
    logic                armed_reg, armed_next;
    logic                pending_reg, pending_next;

    logic [TICK_W-1:0]   lim1, lim2, lim5, tick_inc;
    logic [10:0]         pos_inc, size;
    logic                handle, timeout, do_nak, do_purge, do_finish, arm_en;
    logic [TICK_W-1:0]   arm_limit;
    desc_t               d;

    // timeout limits for one, two and five seconds
    assign lim1     = {3'b000, ticks_per_second};
    assign lim2     = {2'b00, ticks_per_second, 1'b0};
    assign lim5     = {3'b000, ticks_per_second} + {1'b0, ticks_per_second, 2'b00};
    assign tick_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 19'd1;
    assign pos_inc  = pos_reg + 11'd1;
    assign size     = large_reg ? 11'(LARGE_BLOCK_BYTES) : 11'(SMALL_BLOCK_BYTES);

    // next state and result descriptor
    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        sum_next      = sum_reg;
        pos_next      = pos_reg;
        large_next    = large_reg;
        elapsed_next  = elapsed_reg;
        limit_next    = limit_reg;
        armed_next    = armed_reg;
        pending_next  = pending_reg;
        d             = '0;
        handle        = 1'b0;
        timeout       = 1'b0;
        do_nak        = 1'b0;
        do_purge      = 1'b0;
        do_finish     = 1'b0;
        arm_en        = 1'b0;
        arm_limit     = lim1;

        // classify the transaction
        if (accept && phase_reg != PH_ENDED)
        begin
            case (cmd)
                CMD_BYTE:
                begin
                    handle = 1'b1;
                end
                CMD_TICK:
                begin
                    if (armed_reg)
                    begin
                        elapsed_next = tick_inc;
                        if (tick_inc > limit_reg)
                        begin
                            armed_next = 1'b0;
                            handle     = 1'b1;
                            timeout    = 1'b1;
                        end
                    end
                end
                CMD_ABORT:
                begin
                    do_finish = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // per-phase handling of a byte or a timeout
        if (handle)
        begin
            case (phase_reg)
                PH_WAIT_HEADER:
                begin
                    if (timeout)
                        do_nak = 1'b1;
                    else if (line_byte == CAN_BYTE)
                        do_finish = 1'b1;
                    else if (line_byte == EOT_BYTE)
                    begin
                        d         = add_lead(d, KIND_TX, ACK_BYTE);
                        do_finish = 1'b1;
                    end
                    else if (line_byte == SOH_BYTE || line_byte == STX_BYTE)
                    begin
                        large_next = (line_byte == STX_BYTE);
                        arm_en     = 1'b1;
                        phase_next = PH_BLOCK_NUM;
                    end
                    else
                        do_nak = 1'b1;
                end
                PH_PURGE:
                begin
                    if (timeout)
                        do_nak = 1'b1;
                    else
                        do_purge = 1'b1;
                end
                PH_BLOCK_NUM:
                begin
                    if (timeout)
                        do_purge = 1'b1;
                    else
                    begin
                        received_next = line_byte;
                        phase_next    = PH_BLOCK_COMP;
                        arm_en        = 1'b1;
                    end
                end
                PH_BLOCK_COMP:
                begin
                    if (timeout || line_byte != ~received_reg)
                        do_purge = 1'b1;
                    else if (received_reg != expected_reg &&
                             received_reg != expected_reg - 8'd1)
                        do_finish = 1'b1;
                    else
                    begin
                        pos_next   = '0;
                        sum_next   = '0;
                        phase_next = PH_DATA;
                        arm_en     = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    if (timeout)
                        do_purge = 1'b1;
                    else
                    begin
                        sum_next     = sum_reg + line_byte;
                        d            = add_lead(d, KIND_DATA, line_byte);
                        pending_next = 1'b1;
                        pos_next     = pos_inc;
                        if (pos_inc >= size)
                            phase_next = PH_CHECKSUM;
                        arm_en = 1'b1;
                    end
                end
                PH_CHECKSUM:
                begin
                    if (timeout || line_byte != sum_reg)
                        do_purge = 1'b1;
                    else
                    begin
                        if (received_reg == expected_reg)
                        begin
                            d             = add_lead(d, KIND_COMMIT, 8'h00);
                            expected_next = expected_reg + 8'd1;
                        end
                        else
                            d = add_lead(d, KIND_DISCARD, 8'h00);
                        pending_next = 1'b0;
                        d            = add_lead(d, KIND_TX, ACK_BYTE);
                        phase_next   = PH_WAIT_HEADER;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // drop the tentative block and wait for the line to go quiet
        if (do_purge)
        begin
            if (pending_reg)
                d = add_lead(d, KIND_DISCARD, 8'h00);
            pending_next = 1'b0;
            phase_next   = PH_PURGE;
            arm_en       = 1'b1;
            arm_limit    = lim2;
        end

        // negative acknowledge, then wait for a header
        if (do_nak)
        begin
            d          = add_lead(d, KIND_TX, NAK_BYTE);
            arm_en     = 1'b1;
            arm_limit  = lim5;
            phase_next = PH_WAIT_HEADER;
        end

        // timer restart
        if (arm_en)
        begin
            elapsed_next = '0;
            limit_next   = arm_limit;
            armed_next   = 1'b1;
        end

        // cancel the transfer
        if (do_finish)
        begin
            if (pending_reg)
                d = add_lead(d, KIND_DISCARD, 8'h00);
            pending_next = 1'b0;
            d.burst      = 1'b1;
            d.valid      = 1'b1;
            phase_next   = PH_ENDED;
            armed_next   = 1'b0;
        end
    end

    assign desc = d;

    // protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT_HEADER;
            expected_reg <= 8'd1;
            received_reg <= '0;
            sum_reg      <= '0;
            pos_reg      <= '0;
            large_reg    <= 1'b0;
            elapsed_reg  <= '0;
            limit_reg    <= '0;
            armed_reg    <= 1'b1;
            pending_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            sum_reg      <= sum_next;
            pos_reg      <= pos_next;
            large_reg    <= large_next;
            elapsed_reg  <= elapsed_next;
            limit_reg    <= limit_next;
            armed_reg    <= armed_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

[hdl/xmr_queue.sv]
// xmr_queue: short descriptor queue between front and back
// depends on xmr_pkg for the descriptor type and depth

module xmr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  xmr_pkg::desc_t din,
    input  logic           pop,
    output xmr_pkg::desc_t dout,
    output logic           full,
    output logic           empty
);
    import xmr_pkg::*;

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

[hdl/xmr_back.sv]
// xmr_back: expands descriptors into results, one per cycle while popped
// depends on xmr_pkg; drives the registered result ports

module xmr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  xmr_pkg::desc_t head,
    input  logic           q_empty,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic [2:0]     result_kind,
    output logic [7:0]     result_byte,
    output logic           is_last
);
    import xmr_pkg::*;

    desc_t             cur_reg, cur_next;
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic [STEP_W-1:0] cnt_ext, burst_idx;
    kind_t             item_kind;
    logic [7:0]        item_byte;
    logic              item_last, adv;

    // current item of the working descriptor
    assign cnt_ext   = {3'b000, cur_reg.cnt};
    assign burst_idx = step_reg - cnt_ext;

    always_comb
    begin
        item_kind = KIND_END;
        item_byte = 8'h00;
        if (step_reg < cnt_ext)
        begin
            item_kind = step_reg[0] ? cur_reg.kind1 : cur_reg.kind0;
            item_byte = step_reg[0] ? cur_reg.byte1 : cur_reg.byte0;
        end
        else if (burst_idx < STEP_W'(BURST_LEN))
        begin
            item_kind = KIND_TX;
            item_byte = CAN_BYTE;
        end
        else if (burst_idx < STEP_W'(2 * BURST_LEN))
        begin
            item_kind = KIND_TX;
            item_byte = BS_BYTE;
        end
        if (cur_reg.burst)
            item_last = (burst_idx == STEP_W'(2 * BURST_LEN));
        else
            item_last = (step_reg + STEP_W'(1) == cnt_ext);
    end

    // output stage moves when empty or being taken
    assign adv = !out_valid_reg || pop;

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        if (adv)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                out_kind_next = item_kind;
                out_byte_next = item_byte;
                out_last_next = item_last;
                step_next     = step_reg + STEP_W'(1);
            end
        end
        // load the next descriptor when idle or when the current one is done
        if ((!busy_reg || (adv && item_last)) && !q_empty)
        begin
            q_pop     = 1'b1;
            cur_next  = head;
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg && adv && item_last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign empty       = !out_valid_reg;
    assign result_kind = out_kind_reg;
    assign result_byte = out_byte_reg;
    assign is_last     = out_last_reg;

endmodule
